>>> sv/rcpdtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse differential thrust mixer: shared package
// Widths, output range constants, register indices, controller states and
// the command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package rcpdtm_pkg;

  // Field widths.
  localparam int W_W = 15;  // pulse widths and width limits
  localparam int M_W = 12;  // motor commands and motor limits

  // Output ranges of the two linear mappings.
  localparam int THRUST_OUT_LOW  = 1000;
  localparam int THRUST_OUT_HIGH = 2000;
  localparam int DIFF_OUT_LOW    = 0;
  localparam int DIFF_OUT_HIGH   = 200;

  // Datapath widths, all derived from the field widths.
  localparam int OFF_W   = W_W + 2;         // signed difference of two widths
  localparam int RANGE_W = M_W + 1;         // signed output range (d - c)
  localparam int PROD_W  = OFF_W + RANGE_W; // signed product
  localparam int NUM_W   = PROD_W - 1;      // dividend magnitude
  localparam int DEN_W   = OFF_W - 1;       // divisor magnitude
  localparam int VAL_W   = PROD_W + 1;      // mapped value with offset
  localparam int SUM_W   = VAL_W + 1;       // thrust plus or minus differential

  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Reset values of the configuration registers.
  localparam logic [W_W-1:0] TRIGGER_LOW_RST  = W_W'(1000);
  localparam logic [W_W-1:0] TRIGGER_MID_RST  = W_W'(1500);
  localparam logic [W_W-1:0] TRIGGER_HIGH_RST = W_W'(2000);
  localparam logic [W_W-1:0] WHEEL_LOW_RST    = W_W'(1000);
  localparam logic [W_W-1:0] WHEEL_MID_RST    = W_W'(1500);
  localparam logic [W_W-1:0] WHEEL_HIGH_RST   = W_W'(2000);
  localparam logic [M_W-1:0] MOTOR_LOW_RST    = M_W'(1000);
  localparam logic [M_W-1:0] MOTOR_HIGH_RST   = M_W'(2000);

  typedef enum logic [2:0] {
    REG_TRIGGER_LOW    = 3'd0,
    REG_TRIGGER_MIDDLE = 3'd1,
    REG_TRIGGER_HIGH   = 3'd2,
    REG_WHEEL_LOW      = 3'd3,
    REG_WHEEL_MIDDLE   = 3'd4,
    REG_WHEEL_HIGH     = 3'd5,
    REG_MOTOR_LOW      = 3'd6,
    REG_MOTOR_HIGH     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_MAP,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic capture;   // take the input widths, update the held widths
    logic multiply;  // form offsets, spans and products
    logic load;      // load both dividers with magnitudes
    logic step;      // one restoring division step
    logic map;       // apply signs and range starts
    logic mix;       // sum, difference, clamp, fill the output register
  } cmd_t;

endpackage

>>> sv/rcpdtm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse differential thrust mixer: iterative divider
// Unsigned restoring division, one quotient bit per step.
// ----------------------------------------------------------------------------
module rcpdtm_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    trial   = shifted - {1'b0, den_r};
    if (shifted >= {1'b0, den_r}) begin
      rem_nxt = trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

>>> sv/rcpdtm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse differential thrust mixer: datapath
// Configuration registers, held widths, products, two dividers and the
// motor mixing stage with its output register.
// ----------------------------------------------------------------------------
module rcpdtm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rcpdtm_pkg::cmd_t              cmd,
  input  logic                          cfg_we,
  input  rcpdtm_pkg::reg_idx_t          cfg_index,
  input  logic [rcpdtm_pkg::W_W-1:0]    cfg_data,
  input  logic [rcpdtm_pkg::W_W-1:0]    in_trigger_width,
  input  logic [rcpdtm_pkg::W_W-1:0]    in_wheel_width,
  output logic [rcpdtm_pkg::M_W-1:0]    out_front_command,
  output logic [rcpdtm_pkg::M_W-1:0]    out_rear_command,
  output logic [rcpdtm_pkg::W_W-1:0]    out_trigger_used,
  output logic [rcpdtm_pkg::W_W-1:0]    out_wheel_used
);

  import rcpdtm_pkg::*;

  localparam logic signed [RANGE_W-1:0] THRUST_RANGE =
    RANGE_W'(THRUST_OUT_HIGH - THRUST_OUT_LOW);
  localparam logic signed [RANGE_W-1:0] DIFF_RANGE =
    RANGE_W'(DIFF_OUT_HIGH - DIFF_OUT_LOW);

  // Configuration registers.
  logic [W_W-1:0] trig_low_r, trig_mid_r, trig_high_r;
  logic [W_W-1:0] wheel_low_r, wheel_mid_r, wheel_high_r;
  logic [M_W-1:0] motor_low_r, motor_high_r;

  // Held widths; after a capture they are also the widths in use.
  logic [W_W-1:0] held_trig_r, held_trig_nxt;
  logic [W_W-1:0] held_wheel_r, held_wheel_nxt;

  // Product stage.
  logic signed [OFF_W-1:0]  t_off, w_off, t_span, w_span;
  logic [W_W-1:0]           w_end;
  logic                     wheel_pos;
  logic signed [PROD_W-1:0] t_prod_r, w_prod_r;
  logic signed [OFF_W-1:0]  t_span_r, w_span_r;
  logic                     wheel_pos_r;

  // Divider load stage.
  logic [NUM_W-1:0] t_num, w_num;
  logic [DEN_W-1:0] t_den, w_den;
  logic             t_qneg_r, w_qneg_r, t_zero_r, w_zero_r;
  logic [NUM_W-1:0] t_quo, w_quo;

  // Mapping and mixing stages.
  logic signed [VAL_W-1:0] t_sq, w_sq, w_map;
  logic signed [VAL_W-1:0] thrust_r, thrust_nxt, diff_r, diff_nxt;
  logic signed [SUM_W-1:0] front_sum, rear_sum;

  logic [M_W-1:0] front_r, rear_r;
  logic [W_W-1:0] trig_used_r, wheel_used_r;

  function automatic logic [W_W-1:0] clamp_width(input logic [W_W-1:0] w,
                                                 input logic [W_W-1:0] lo,
                                                 input logic [W_W-1:0] hi);
    logic [W_W-1:0] v;
    v = w;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // The low limit is checked first, so with inverted limits a sum below the
  // low limit gives the low limit and any other sum gives the high limit.
  function automatic logic [M_W-1:0] clamp_motor(input logic signed [SUM_W-1:0] v,
                                                 input logic [M_W-1:0] lo,
                                                 input logic [M_W-1:0] hi);
    logic [M_W-1:0] r;
    if (v < $signed(SUM_W'(lo))) r = lo;
    else if (v > $signed(SUM_W'(hi))) r = hi;
    else r = v[M_W-1:0];
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_low_r   <= TRIGGER_LOW_RST;
      trig_mid_r   <= TRIGGER_MID_RST;
      trig_high_r  <= TRIGGER_HIGH_RST;
      wheel_low_r  <= WHEEL_LOW_RST;
      wheel_mid_r  <= WHEEL_MID_RST;
      wheel_high_r <= WHEEL_HIGH_RST;
      motor_low_r  <= MOTOR_LOW_RST;
      motor_high_r <= MOTOR_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_LOW:    trig_low_r   <= cfg_data;
        REG_TRIGGER_MIDDLE: trig_mid_r   <= cfg_data;
        REG_TRIGGER_HIGH:   trig_high_r  <= cfg_data;
        REG_WHEEL_LOW:      wheel_low_r  <= cfg_data;
        REG_WHEEL_MIDDLE:   wheel_mid_r  <= cfg_data;
        REG_WHEEL_HIGH:     wheel_high_r <= cfg_data;
        REG_MOTOR_LOW:      motor_low_r  <= cfg_data[M_W-1:0];
        REG_MOTOR_HIGH:     motor_high_r <= cfg_data[M_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold on a missing pulse, otherwise clamp and hold.
  always_comb begin
    held_trig_nxt  = held_trig_r;
    held_wheel_nxt = held_wheel_r;
    if (cmd.capture) begin
      if (in_trigger_width != '0)
        held_trig_nxt = clamp_width(in_trigger_width, trig_low_r, trig_high_r);
      if (in_wheel_width != '0)
        held_wheel_nxt = clamp_width(in_wheel_width, wheel_low_r, wheel_high_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_trig_r  <= TRIGGER_MID_RST;
      held_wheel_r <= WHEEL_MID_RST;
    end else begin
      held_trig_r  <= held_trig_nxt;
      held_wheel_r <= held_wheel_nxt;
    end
  end

  // Offsets, spans and products.
  always_comb begin
    wheel_pos = (held_wheel_r >= wheel_mid_r);
    w_end     = wheel_pos ? wheel_high_r : wheel_low_r;
    t_off     = $signed({2'b00, held_trig_r}) - $signed({2'b00, trig_mid_r});
    t_span    = $signed({2'b00, trig_high_r}) - $signed({2'b00, trig_mid_r});
    w_off     = $signed({2'b00, held_wheel_r}) - $signed({2'b00, wheel_mid_r});
    w_span    = $signed({2'b00, w_end}) - $signed({2'b00, wheel_mid_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      t_prod_r    <= PROD_W'(t_off) * PROD_W'(THRUST_RANGE);
      w_prod_r    <= PROD_W'(w_off) * PROD_W'(DIFF_RANGE);
      t_span_r    <= t_span;
      w_span_r    <= w_span;
      wheel_pos_r <= wheel_pos;
    end
  end

  // Magnitudes for the dividers; the quotient sign is restored afterwards,
  // which gives division truncating towards zero.
  always_comb begin
    t_num = t_prod_r[PROD_W-1] ? NUM_W'(-t_prod_r) : NUM_W'(t_prod_r);
    w_num = w_prod_r[PROD_W-1] ? NUM_W'(-w_prod_r) : NUM_W'(w_prod_r);
    t_den = t_span_r[OFF_W-1] ? DEN_W'(-t_span_r) : DEN_W'(t_span_r);
    w_den = w_span_r[OFF_W-1] ? DEN_W'(-w_span_r) : DEN_W'(w_span_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_qneg_r <= t_prod_r[PROD_W-1] ^ t_span_r[OFF_W-1];
      w_qneg_r <= w_prod_r[PROD_W-1] ^ w_span_r[OFF_W-1];
      t_zero_r <= (t_span_r == '0);
      w_zero_r <= (w_span_r == '0);
    end
  end

  rcpdtm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_thrust (
    .clk  (clk),
    .load (cmd.load),
    .step (cmd.step),
    .num  (t_num),
    .den  (t_den),
    .quo  (t_quo)
  );

  rcpdtm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div_diff (
    .clk  (clk),
    .load (cmd.load),
    .step (cmd.step),
    .num  (w_num),
    .den  (w_den),
    .quo  (w_quo)
  );

  // A zero span maps to the range start.
  always_comb begin
    if (t_zero_r) t_sq = '0;
    else if (t_qneg_r) t_sq = -$signed(VAL_W'(t_quo));
    else t_sq = $signed(VAL_W'(t_quo));
    if (w_zero_r) w_sq = '0;
    else if (w_qneg_r) w_sq = -$signed(VAL_W'(w_quo));
    else w_sq = $signed(VAL_W'(w_quo));
    thrust_nxt = t_sq + VAL_W'(THRUST_OUT_LOW);
    w_map      = w_sq + VAL_W'(DIFF_OUT_LOW);
    diff_nxt   = wheel_pos_r ? w_map : -w_map;
  end

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      thrust_r <= thrust_nxt;
      diff_r   <= diff_nxt;
    end
  end

  always_comb begin
    front_sum = SUM_W'(thrust_r) + SUM_W'(diff_r);
    rear_sum  = SUM_W'(thrust_r) - SUM_W'(diff_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      front_r      <= clamp_motor(front_sum, motor_low_r, motor_high_r);
      rear_r       <= clamp_motor(rear_sum, motor_low_r, motor_high_r);
      trig_used_r  <= held_trig_r;
      wheel_used_r <= held_wheel_r;
    end
  end

  assign out_front_command = front_r;
  assign out_rear_command  = rear_r;
  assign out_trigger_used  = trig_used_r;
  assign out_wheel_used    = wheel_used_r;

endmodule

>>> sv/rcpdtm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse differential thrust mixer: controller
// Sequences one frame through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module rcpdtm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rcpdtm_pkg::cmd_t cmd
);

  import rcpdtm_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.multiply = 1'b1;
        state_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MAP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        // The output register is refilled only once its transfer has gone.
        if (!out_valid_r || out_ready) begin
          cmd.mix       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= CNT_W'(DIV_STEPS - 1))
    else $error("division step count out of range");

  a_map_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAP |-> $past(state_r) == ST_DIV &&
                          $past(cnt_r) == CNT_W'(DIV_STEPS - 1))
    else $error("mapping entered before all division steps");

  a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_MIX)
    else $error("result offered without a mixing step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix |-> !out_valid_r || out_ready)
    else $error("output register overwritten before its transfer");

endmodule

>>> sv/rc_pulse_differential_thrust_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse differential thrust mixer
// Turns trigger and wheel pulse widths into front and rear motor commands.
// ----------------------------------------------------------------------------
// One input transfer carries a radio frame: the trigger and wheel pulse widths
// in microseconds, where zero means no pulse and the last good width of that
// channel is reused. Other widths are clamped to the channel limits and held.
// The trigger maps from its middle to its high limit onto thrust 1000..2000;
// the wheel maps from its middle towards its high or low limit onto a signed
// differential of up to 200, with division truncating towards zero and a zero
// span giving the range start. Front is thrust plus differential, rear is
// thrust minus differential, both clamped to the motor limits. Each frame
// yields exactly one result transfer. Between one accepted transfer and the
// next, a frame goes through these steps in order: capture, product, divider
// load, 29 steps of the two restoring dividers that run side by side (one
// quotient bit per cycle), mapping and mixing. The result sits in an output
// register, so the next frame is accepted while it waits; the mixing step of
// that next frame waits only if the previous result is still untaken. The
// held widths start at the middle reset values and are not changed by
// configuration writes, which should be made while the block is idle.
// ----------------------------------------------------------------------------
module rc_pulse_differential_thrust_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_we,
  input  rcpdtm_pkg::reg_idx_t          cfg_index,
  input  logic [rcpdtm_pkg::W_W-1:0]    cfg_data,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rcpdtm_pkg::W_W-1:0]    in_trigger_width,
  input  logic [rcpdtm_pkg::W_W-1:0]    in_wheel_width,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rcpdtm_pkg::M_W-1:0]    out_front_command,
  output logic [rcpdtm_pkg::M_W-1:0]    out_rear_command,
  output logic [rcpdtm_pkg::W_W-1:0]    out_trigger_used,
  output logic [rcpdtm_pkg::W_W-1:0]    out_wheel_used
);

  import rcpdtm_pkg::*;

  // The controller's only link to the datapath is this command bundle.
  cmd_t cmd;

  rcpdtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the held widths, both dividers
  // and the output register.
  rcpdtm_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_trigger_width  (in_trigger_width),
    .in_wheel_width    (in_wheel_width),
    .out_front_command (out_front_command),
    .out_rear_command  (out_rear_command),
    .out_trigger_used  (out_trigger_used),
    .out_wheel_used    (out_wheel_used)
  );

endmodule
